// ===== hw/rtl/cpfa_pkg.sv =====
// Shared types, widths and codes for the contiguous page frame allocator.
package cpfa_pkg;

   localparam int NUM_FRAMES = 1024;
   localparam int FRAME_W    = $clog2(NUM_FRAMES);
   localparam int SCAN_W     = 16;   // holds a frame index plus one run length
   localparam int WORD_W     = 16;
   localparam int LEN_W      = 15;

   localparam int OP_W      = 1;
   localparam int PAGE_W    = 15;
   localparam int FIDX_W    = 10;
   localparam int STATUS_W  = 2;
   localparam int START_W   = 10;
   localparam int FREED_W   = 11;
   localparam int USED_W    = 11;
   localparam int RESV_W    = 11;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_RESERVED = CSR_IDX_W'(0);

   localparam logic [WORD_W-1:0] MAP_FREE_WORD = 16'h0001;
   localparam logic [WORD_W-1:0] MAP_LEN_MASK  = 16'hFFFE;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOC_FAIL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREE_REJECT = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FCHK,
      ST_WALK,
      ST_REL,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/cpfa_req_if.sv =====
// Request channel: op, page count and frame index.
interface cpfa_req_if;
   logic                           valid;
   logic                           ready;
   logic [cpfa_pkg::OP_W-1:0]      op;
   logic [cpfa_pkg::PAGE_W-1:0]    page_count;
   logic [cpfa_pkg::FIDX_W-1:0]    frame_index;

   modport source (output valid, op, page_count, frame_index, input ready);
   modport sink   (input valid, op, page_count, frame_index, output ready);
endinterface

// ===== hw/rtl/cpfa_rsp_if.sv =====
// Response channel: status, start frame, freed pages and frames in use.
interface cpfa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cpfa_pkg::STATUS_W-1:0]   status;
   logic [cpfa_pkg::START_W-1:0]    start_frame;
   logic [cpfa_pkg::FREED_W-1:0]    freed_pages;
   logic [cpfa_pkg::USED_W-1:0]     frames_in_use;

   modport source (output valid, status, start_frame, freed_pages, frames_in_use, input ready);
   modport sink   (input valid, status, start_frame, freed_pages, frames_in_use, output ready);
endinterface

// ===== hw/rtl/contiguous_page_frame_allocator_unit.sv =====
// First-fit contiguous page frame allocator with the frame map in one RAM.
//
//  channel   dir   handshake        payload
//  req_ch    in    valid/ready      op, page_count, frame_index
//  rsp_ch    out   valid/ready      status, start_frame, freed_pages, frames_in_use
//  csr_*     in    APB write/read   reserved_frames at byte address 0
//
// One map word is read or written per cycle (single RAM, registered read).
// Allocate: the scan visits map words (at most NUM_FRAMES), then the pages are marked.
// Free: the frame is checked, walked back to the run start, then the run is released.
// Reset and each reserved_frames write rebuild the whole map (NUM_FRAMES = 1024 words)
// with req_ch.ready low. A finished response waits in rsp registers;
// a stalled rsp_ch holds the next result in ST_RESP.
module contiguous_page_frame_allocator_unit (
   input  logic                             clock,
   input  logic                             reset,
   cpfa_req_if.sink                         req_ch,
   cpfa_rsp_if.source                       rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cpfa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cpfa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cpfa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int FW = cpfa_pkg::FRAME_W;
   localparam int SW = cpfa_pkg::SCAN_W;

   // frame map: bit 0 free, bits 15..1 run length on a run's first frame
   logic [cpfa_pkg::WORD_W-1:0] map_mem [cpfa_pkg::NUM_FRAMES];
   logic [cpfa_pkg::WORD_W-1:0] mem_rd_data_ff;
   logic [FW-1:0]               mem_rd_addr;
   logic                        mem_we;
   logic [FW-1:0]               mem_waddr;
   logic [cpfa_pkg::WORD_W-1:0] mem_wdata;

   cpfa_pkg::state_type state_ff, state_in;

   logic [cpfa_pkg::PAGE_W-1:0]   page_ff, page_in;
   logic [SW-1:0]                 i_ff, i_in;
   logic [SW-1:0]                 cnt_ff, cnt_in;
   logic [SW-1:0]                 found_ff, found_in;
   logic [FW-1:0]                 ptr_ff, ptr_in;
   logic [cpfa_pkg::LEN_W-1:0]    rem_ff, rem_in;
   logic [FW-1:0]                 s_ff, s_in;
   logic [FW-1:0]                 clr_ff, clr_in;
   logic [cpfa_pkg::USED_W-1:0]   used_ff, used_in;
   logic [cpfa_pkg::RESV_W-1:0]   resv_ff, resv_in;
   logic [cpfa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [cpfa_pkg::START_W-1:0]  res_start_ff, res_start_in;
   logic [cpfa_pkg::FREED_W-1:0]  res_freed_ff, res_freed_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cpfa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [cpfa_pkg::START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [cpfa_pkg::FREED_W-1:0]  rsp_freed_ff, rsp_freed_in;
   logic [cpfa_pkg::USED_W-1:0]   rsp_used_ff, rsp_used_in;

   logic                          csr_wr;
   logic [cpfa_pkg::RESV_W-1:0]   csr_raw;
   logic [cpfa_pkg::RESV_W-1:0]   csr_clamped;
   logic [cpfa_pkg::LEN_W-1:0]    rd_len;
   logic [SW-1:0]                 i_jump;
   logic [SW:0]                   fit_end;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[cpfa_pkg::CSR_ADDR_W-1:2] == cpfa_pkg::REG_RESERVED);
   assign csr_raw    = csr_pwdata[cpfa_pkg::RESV_W-1:0];

   always_comb begin
      if (csr_raw == '0) begin
         csr_clamped = cpfa_pkg::RESV_W'(1);
      end else if (SW'(csr_raw) > SW'(cpfa_pkg::NUM_FRAMES)) begin
         csr_clamped = cpfa_pkg::RESV_W'(cpfa_pkg::NUM_FRAMES);
      end else begin
         csr_clamped = csr_raw;
      end
   end

   always_comb begin
      if (csr_paddr[cpfa_pkg::CSR_ADDR_W-1:2] == cpfa_pkg::REG_RESERVED) begin
         csr_prdata = cpfa_pkg::CSR_DATA_W'(resv_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign rd_len  = mem_rd_data_ff[cpfa_pkg::WORD_W-1:1];
   assign i_jump  = i_ff + SW'(rd_len);
   assign fit_end = {1'b0, found_ff} + (SW+1)'(page_ff);

   assign req_ch.ready        = (state_ff == cpfa_pkg::ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.start_frame  = rsp_start_ff;
   assign rsp_ch.freed_pages  = rsp_freed_ff;
   assign rsp_ch.frames_in_use = rsp_used_ff;

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      i_in          = i_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      s_in          = s_ff;
      clr_in        = clr_ff;
      used_in       = used_ff;
      resv_in       = resv_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_freed_in  = res_freed_ff;
      mem_rd_addr   = '0;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_used_in   = rsp_used_ff;

      unique case (state_ff)
         cpfa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == '0) begin
               mem_wdata = cpfa_pkg::WORD_W'({resv_ff, 1'b0}) & cpfa_pkg::MAP_LEN_MASK;
            end else if (SW'(clr_ff) < SW'(resv_ff)) begin
               mem_wdata = '0;
            end else begin
               mem_wdata = cpfa_pkg::MAP_FREE_WORD;
            end
            clr_in = clr_ff + FW'(1);
            if (clr_ff == FW'(cpfa_pkg::NUM_FRAMES - 1)) begin
               state_in = cpfa_pkg::ST_IDLE;
            end
         end

         cpfa_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               page_in       = req_ch.page_count;
               res_status_in = cpfa_pkg::STATUS_DONE;
               res_start_in  = '0;
               res_freed_in  = '0;
               if (req_ch.op == cpfa_pkg::OP_ALLOC) begin
                  if (req_ch.page_count == '0
                      || SW'(req_ch.page_count) > SW'(cpfa_pkg::NUM_FRAMES)) begin
                     // cannot fit anywhere: map untouched
                     res_status_in = cpfa_pkg::STATUS_ALLOC_FAIL;
                     state_in      = cpfa_pkg::ST_RESP;
                  end else begin
                     i_in        = '0;
                     cnt_in      = '0;
                     found_in    = '0;
                     mem_rd_addr = '0;
                     state_in    = cpfa_pkg::ST_SCAN;
                  end
               end else begin
                  s_in = req_ch.frame_index;
                  if (SW'(req_ch.frame_index) >= SW'(cpfa_pkg::NUM_FRAMES)
                      || SW'(req_ch.frame_index) < SW'(resv_ff)) begin
                     res_status_in = cpfa_pkg::STATUS_FREE_REJECT;
                     state_in      = cpfa_pkg::ST_RESP;
                  end else begin
                     mem_rd_addr = FW'(req_ch.frame_index);
                     state_in    = cpfa_pkg::ST_FCHK;
                  end
               end
            end
         end

         cpfa_pkg::ST_SCAN: begin
            if (cnt_ff >= SW'(page_ff) || i_ff >= SW'(cpfa_pkg::NUM_FRAMES)) begin
               if (cnt_ff == SW'(page_ff) && fit_end <= (SW+1)'(cpfa_pkg::NUM_FRAMES)) begin
                  ptr_in       = FW'(found_ff);
                  rem_in       = page_ff;
                  used_in      = used_ff + cpfa_pkg::USED_W'(page_ff);
                  res_start_in = cpfa_pkg::START_W'(found_ff);
                  state_in     = cpfa_pkg::ST_MARK;
               end else begin
                  res_status_in = cpfa_pkg::STATUS_ALLOC_FAIL;
                  state_in      = cpfa_pkg::ST_RESP;
               end
            end else if (rd_len != '0) begin
               // skip over an allocated run
               i_in        = i_jump;
               found_in    = i_jump;
               cnt_in      = '0;
               mem_rd_addr = FW'(i_jump);
            end else begin
               i_in        = i_ff + SW'(1);
               cnt_in      = cnt_ff + SW'(1);
               mem_rd_addr = FW'(i_ff + SW'(1));
            end
         end

         cpfa_pkg::ST_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            if (ptr_ff == FW'(found_ff)) begin
               mem_wdata = cpfa_pkg::WORD_W'({page_ff, 1'b0}) & cpfa_pkg::MAP_LEN_MASK;
            end else begin
               mem_wdata = '0;
            end
            ptr_in = ptr_ff + FW'(1);
            rem_in = rem_ff - cpfa_pkg::LEN_W'(1);
            if (rem_ff == cpfa_pkg::LEN_W'(1)) begin
               state_in = cpfa_pkg::ST_RESP;
            end
         end

         cpfa_pkg::ST_FCHK: begin
            if (mem_rd_data_ff[0]) begin
               res_status_in = cpfa_pkg::STATUS_FREE_REJECT;
               state_in      = cpfa_pkg::ST_RESP;
            end else begin
               mem_rd_addr = s_ff;
               state_in    = cpfa_pkg::ST_WALK;
            end
         end

         cpfa_pkg::ST_WALK: begin
            if (s_ff != '0 && rd_len == '0) begin
               s_in        = s_ff - FW'(1);
               mem_rd_addr = s_ff - FW'(1);
            end else begin
               ptr_in       = s_ff;
               rem_in       = rd_len;
               res_freed_in = cpfa_pkg::FREED_W'(rd_len);
               if (cpfa_pkg::LEN_W'(used_ff) >= rd_len) begin
                  used_in = used_ff - cpfa_pkg::USED_W'(rd_len);
               end else begin
                  used_in = '0;
               end
               if (rd_len == '0) begin
                  state_in = cpfa_pkg::ST_RESP;
               end else begin
                  state_in = cpfa_pkg::ST_REL;
               end
            end
         end

         cpfa_pkg::ST_REL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = cpfa_pkg::MAP_FREE_WORD;
            ptr_in    = ptr_ff + FW'(1);
            rem_in    = rem_ff - cpfa_pkg::LEN_W'(1);
            // stop at the run end or the top of the map
            if (rem_ff == cpfa_pkg::LEN_W'(1) || ptr_ff == FW'(cpfa_pkg::NUM_FRAMES - 1)) begin
               state_in = cpfa_pkg::ST_RESP;
            end
         end

         cpfa_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_freed_in  = res_freed_ff;
               rsp_used_in   = used_ff;
               state_in      = cpfa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cpfa_pkg::ST_IDLE;
         end
      endcase

      // register write rebuilds the map
      if (csr_wr) begin
         resv_in  = csr_clamped;
         used_in  = cpfa_pkg::USED_W'(csr_clamped);
         clr_in   = '0;
         state_in = cpfa_pkg::ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpfa_pkg::ST_CLEAR;
         clr_ff       <= '0;
         resv_ff      <= cpfa_pkg::RESV_W'(1);
         used_ff      <= cpfa_pkg::USED_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         resv_ff      <= resv_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      i_ff          <= i_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      s_ff          <= s_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_freed_ff  <= res_freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_used_ff   <= rsp_used_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_data_ff <= map_mem[mem_rd_addr];
   end

`ifndef SYNTHESIS
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpfa_pkg::ST_CLEAR) |-> !req_ch.ready)
      else $error("request taken while the map is being rebuilt");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(used_ff) <= SW'(cpfa_pkg::NUM_FRAMES))
      else $error("frames in use exceeds the map size");

   a_resv_range: assert property (@(posedge clock) disable iff (reset)
      resv_ff != '0 && SW'(resv_ff) <= SW'(cpfa_pkg::NUM_FRAMES))
      else $error("reserved frame count out of range");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpfa_pkg::ST_SCAN) |-> (cnt_ff <= SW'(page_ff)))
      else $error("scan counted past the requested page count");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != cpfa_pkg::STATUS_DONE)
      |-> (rsp_start_ff == '0 && rsp_freed_ff == '0))
      else $error("failed transfer carries a start frame or freed pages");

   a_mark_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpfa_pkg::ST_MARK) |-> (fit_end <= (SW+1)'(cpfa_pkg::NUM_FRAMES)))
      else $error("marking a run that runs past the map");
`endif

endmodule

// ===== test/tb_contiguous_page_frame_allocator_unit.sv =====
// Self-checking bench for the first-fit page frame allocator: driver, sink and scoreboard.
`timescale 1ns / 100ps

module tb_contiguous_page_frame_allocator_unit;

   localparam int MAX_RUN = 32'h8000;
   localparam logic [cpfa_pkg::CSR_ADDR_W-1:0] RESERVED_ADDR = {cpfa_pkg::REG_RESERVED, 2'b00};

   typedef struct packed {
      logic [cpfa_pkg::STATUS_W-1:0] status;
      logic [cpfa_pkg::START_W-1:0]  start_frame;
      logic [cpfa_pkg::FREED_W-1:0]  freed_pages;
      logic [cpfa_pkg::USED_W-1:0]   frames_in_use;
   } alloc_result_type;

   // Mirror of the frame map; each accepted request is applied here and its reply queued.
   class alloc_scoreboard;
      bit [cpfa_pkg::WORD_W-1:0] frame_map [cpfa_pkg::NUM_FRAMES];
      int unsigned               in_use;
      int unsigned               reserved;
      int unsigned               fail_count;
      alloc_result_type          outcomes_due [$];

      function new();
         fail_count = 0;
         load_reserved(1);
      endfunction

      function void flag(string msg);
         fail_count++;
         if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      function int unsigned run_length(int unsigned f);
         return int'(frame_map[f][cpfa_pkg::WORD_W-1:1]);
      endfunction

      // Rebuild the map: frames below the reserved count form one run at frame 0.
      function void load_reserved(int unsigned raw);
         int unsigned r;
         int unsigned f;
         r = raw & 32'h7FF;
         if (r == 0) r = 1;
         if (r > cpfa_pkg::NUM_FRAMES) r = cpfa_pkg::NUM_FRAMES;
         reserved = r;
         for (f = 0; f < cpfa_pkg::NUM_FRAMES; f++)
            frame_map[f] = (f < r) ? '0 : cpfa_pkg::MAP_FREE_WORD;
         frame_map[0] = cpfa_pkg::WORD_W'(r << 1) & cpfa_pkg::MAP_LEN_MASK;
         in_use = r;
      endfunction

      // Random frame inside a freeable run, or NUM_FRAMES when none was hit.
      function int unsigned pick_allocated_frame();
         int unsigned f;
         int          tries;
         if (reserved >= cpfa_pkg::NUM_FRAMES) return cpfa_pkg::NUM_FRAMES;
         for (tries = 0; tries < 40; tries++) begin
            f = $urandom_range(reserved, cpfa_pkg::NUM_FRAMES - 1);
            if (frame_map[f][0] == 1'b0) return f;
         end
         return cpfa_pkg::NUM_FRAMES;
      endfunction

      function void note_request(logic [cpfa_pkg::OP_W-1:0] op,
                                 logic [cpfa_pkg::PAGE_W-1:0] page_count,
                                 logic [cpfa_pkg::FIDX_W-1:0] frame_index);
         alloc_result_type r;
         int unsigned      want, fidx, i, run, found, len, s, n, k;
         r = '0;
         want = page_count;
         fidx = frame_index;
         if (op == cpfa_pkg::OP_ALLOC) begin
            if (want == 0 || want >= MAX_RUN) begin
               r.status = cpfa_pkg::STATUS_ALLOC_FAIL;
            end else begin
               i = 0;
               run = 0;
               found = 0;
               // jump whole runs from their head word, count free frames otherwise
               while (run < want && i < cpfa_pkg::NUM_FRAMES) begin
                  len = run_length(i);
                  if (len != 0) begin
                     i += len;
                     found = i;
                     run = 0;
                  end else begin
                     run++;
                     i++;
                  end
               end
               if (run == want && found + want <= cpfa_pkg::NUM_FRAMES) begin
                  for (k = 0; k < want; k++)
                     frame_map[found + k] = '0;
                  frame_map[found] = cpfa_pkg::WORD_W'(want << 1) & cpfa_pkg::MAP_LEN_MASK;
                  in_use += want;
                  r.start_frame = cpfa_pkg::START_W'(found);
               end else begin
                  r.status = cpfa_pkg::STATUS_ALLOC_FAIL;
               end
            end
         end else begin
            if (fidx >= cpfa_pkg::NUM_FRAMES || frame_map[fidx][0] || fidx < reserved) begin
               r.status = cpfa_pkg::STATUS_FREE_REJECT;
            end else begin
               s = fidx;
               while (s > 0 && run_length(s) == 0)
                  s--;
               n = run_length(s);
               for (k = 0; k < n && s + k < cpfa_pkg::NUM_FRAMES; k++)
                  frame_map[s + k] = cpfa_pkg::MAP_FREE_WORD;
               r.freed_pages = cpfa_pkg::FREED_W'(n);
               in_use = (in_use >= n) ? in_use - n : 0;
            end
         end
         r.frames_in_use = cpfa_pkg::USED_W'(in_use);
         outcomes_due.push_back(r);
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         if (outcomes_due.size() == 0) begin
            flag($sformatf("reply with nothing outstanding (status %0d)", got.status));
            return;
         end
         want = outcomes_due.pop_front();
         if (got.status !== want.status)
            flag($sformatf("status expected %0d, got %0d", want.status, got.status));
         if (got.start_frame !== want.start_frame)
            flag($sformatf("start_frame expected %0d, got %0d",
                           want.start_frame, got.start_frame));
         if (got.freed_pages !== want.freed_pages)
            flag($sformatf("freed_pages expected %0d, got %0d",
                           want.freed_pages, got.freed_pages));
         if (got.frames_in_use !== want.frames_in_use)
            flag($sformatf("frames_in_use expected %0d, got %0d",
                           want.frames_in_use, got.frames_in_use));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [cpfa_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cpfa_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cpfa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   int                              idle_pct = 25;

   alloc_scoreboard book = new();

   cpfa_req_if req_bus ();
   cpfa_rsp_if rsp_bus ();

   contiguous_page_frame_allocator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #25_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(1, 3);
   endfunction

   // Reply sink: check each transfer, stall ready at random.
   initial begin
      int stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            book.check_result({rsp_bus.status, rsp_bus.start_frame,
                               rsp_bus.freed_pages, rsp_bus.frames_in_use});
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall = idle_gap();
            rsp_bus.ready <= (stall == 0);
         end
      end
   end

   task automatic issue(input logic [cpfa_pkg::OP_W-1:0] op,
                        input logic [cpfa_pkg::PAGE_W-1:0] page_count,
                        input logic [cpfa_pkg::FIDX_W-1:0] frame_index);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.page_count  <= page_count;
      req_bus.frame_index <= frame_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_request(op, page_count, frame_index);
   endtask

   // Write reserved_frames while idle, then read it back as the block keeps it.
   task automatic write_reserved(input logic [cpfa_pkg::CSR_DATA_W-1:0] value);
      int unsigned kept;
      while (book.outcomes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RESERVED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      book.load_reserved(value);
      kept = book.reserved;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== cpfa_pkg::CSR_DATA_W'(kept))
         book.flag($sformatf("reserved_frames read expected %0d, got %0d", kept, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_directed();
      issue(cpfa_pkg::OP_ALLOC, 15'd0, 10'd1023);       // zero count
      issue(cpfa_pkg::OP_ALLOC, 15'h7FFF, 10'd0);       // largest count
      issue(cpfa_pkg::OP_ALLOC, 15'd1024, 10'd0);       // one more than is free
      issue(cpfa_pkg::OP_ALLOC, 15'd1023, 10'd0);       // fills the map
      issue(cpfa_pkg::OP_ALLOC, 15'd1, 10'd0);          // no fit
      issue(cpfa_pkg::OP_FREE, 15'h7FFF, 10'd0);        // reserved frame
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'd1023);        // long walk back to frame 1
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'd1023);        // already free
      issue(cpfa_pkg::OP_ALLOC, 15'd1, 10'h2AA);
      issue(cpfa_pkg::OP_ALLOC, 15'd3, 10'h155);
      issue(cpfa_pkg::OP_ALLOC, 15'd5, 10'd0);
      issue(cpfa_pkg::OP_FREE, 15'h2AAA, 10'd3);        // middle of a run
      issue(cpfa_pkg::OP_ALLOC, 15'd2, 10'd0);          // reuses the hole
      issue(cpfa_pkg::OP_ALLOC, 15'd2, 10'd0);          // one-frame gap left behind
      issue(cpfa_pkg::OP_FREE, 15'h5555, 10'd9);        // last frame of a run
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'd4);
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'd512);
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'h2AA);
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'h155);
      issue(cpfa_pkg::OP_ALLOC, 15'h5555, 10'd0);
      issue(cpfa_pkg::OP_ALLOC, 15'h2AAA, 10'd0);
      issue(cpfa_pkg::OP_FREE, 15'd0, 10'd11);
      issue(cpfa_pkg::OP_ALLOC, 15'd1000, 10'd0);
   endtask

   task automatic random_item();
      int unsigned                 lean, roll, f;
      logic [cpfa_pkg::PAGE_W-1:0] page_count;
      logic [cpfa_pkg::FIDX_W-1:0] frame_index;
      page_count  = cpfa_pkg::PAGE_W'($urandom);
      frame_index = cpfa_pkg::FIDX_W'($urandom);
      // free more often as the map fills up
      lean = 10 + 80 * (book.in_use - book.reserved)
             / (cpfa_pkg::NUM_FRAMES - book.reserved + 1);
      if ($urandom_range(0, 99) < lean) begin
         f = book.pick_allocated_frame();
         if (f < cpfa_pkg::NUM_FRAMES && $urandom_range(0, 99) < 85)
            frame_index = cpfa_pkg::FIDX_W'(f);
         issue(cpfa_pkg::OP_FREE, page_count, frame_index);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            page_count = cpfa_pkg::PAGE_W'($urandom_range(1, 16));
         else if (roll < 90)
            page_count = cpfa_pkg::PAGE_W'($urandom_range(17, 128));
         else if (roll < 96)
            page_count = cpfa_pkg::PAGE_W'($urandom_range(129, 1024));
         else if (roll < 98)
            page_count = '0;
         issue(cpfa_pkg::OP_ALLOC, page_count, frame_index);
      end
   endtask

   task automatic run_random(input int count, input int pct);
      int n;
      for (n = 0; n < count; n++) begin
         idle_pct = (n % 60 < 15) ? 0 : pct;
         random_item();
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= cpfa_pkg::OP_ALLOC;
      req_bus.page_count  <= '0;
      req_bus.frame_index <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= RESERVED_ADDR;
      csr_pwdata          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(150, 30);
      write_reserved(32'd1024);
      run_random(15, 50);
      write_reserved(32'd0);
      run_random(150, 0);
      write_reserved(32'd2047);
      run_random(10, 20);
      write_reserved(32'd300);
      run_random(100, 30);
      write_reserved(32'd1000);
      run_random(60, 20);
      write_reserved(32'hFFFF_F805);
      run_random(100, 40);

      while (book.outcomes_due.size() != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      if (book.fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
